// ----- sv/elcc_pkg.sv -----
// ----------------------------------------------------------------------------
// elcc_pkg
// Shared types and constants for the extent list canonical checker.
// ----------------------------------------------------------------------------
package elcc_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W      = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_GEOM    = 3'd1,
    ST_MANY    = 3'd2,
    ST_BOUNDS  = 3'd3,
    ST_OVERLAP = 3'd4,
    ST_ORDER   = 3'd5
  } status_t;

  // geometry registers
  typedef struct packed {
    logic [31:0] group_count;
    logic [31:0] group_blocks;
    logic [5:0]  block_log;
  } cfg_t;

  // one classified extent, as it sits in the queue
  typedef struct packed {
    logic [31:0] grp;
    logic [63:0] blk;
    logic [31:0] len;
    logic        last;
    logic [63:0] off;
    logic        geom_bad;
    logic        bounds_bad;
  } item_t;

endpackage

// ----- sv/elcc_regs.sv -----
// ----------------------------------------------------------------------------
// elcc_regs
// APB-style register file holding the group geometry.
// ----------------------------------------------------------------------------
module elcc_regs
  import elcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output cfg_t              cfg
);

  localparam logic [1:0] REG_GROUP_COUNT  = 2'd0;
  localparam logic [1:0] REG_GROUP_BLOCKS = 2'd1;
  localparam logic [1:0] REG_BLOCK_LOG    = 2'd2;

  cfg_t        cfg_r;
  logic        wr_en;
  logic [1:0]  idx;

  assign idx   = paddr[3:2];
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_GROUP_COUNT:  cfg_r.group_count  <= pwdata;
        REG_GROUP_BLOCKS: cfg_r.group_blocks <= pwdata;
        REG_BLOCK_LOG:    cfg_r.block_log    <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GROUP_COUNT:  prdata = cfg_r.group_count;
      REG_GROUP_BLOCKS: prdata = cfg_r.group_blocks;
      REG_BLOCK_LOG:    prdata = {26'd0, cfg_r.block_log};
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- sv/elcc_front.sv -----
// ----------------------------------------------------------------------------
// elcc_front
// Classifies an incoming extent against the geometry: everything that does
// not depend on earlier extents of the list.
// ----------------------------------------------------------------------------
module elcc_front
  import elcc_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [31:0] grp,
  input  logic [63:0] blk,
  input  logic [31:0] len,
  input  logic        last,
  output item_t       item
);

  logic [63:0] off_mask;
  logic [63:0] off;
  logic [63:0] blocks_w;
  logic        geom_bad;
  logic        bounds_bad;

  assign off_mask = (64'd1 << cfg.block_log) - 64'd1;
  assign off      = blk & off_mask;
  assign blocks_w = {32'd0, cfg.group_blocks};
  assign geom_bad = (cfg.group_count == 32'd0) || (cfg.group_blocks == 32'd0) ||
                    (cfg.block_log == 6'd0);

  // the length test only matters when off < blocks, so the wrap is harmless
  assign bounds_bad = (len == 32'd0) || (grp >= cfg.group_count) ||
                      ((blk >> cfg.block_log) != {32'd0, grp}) ||
                      (off >= blocks_w) ||
                      ({32'd0, len} > (blocks_w - off));

  always_comb begin
    item.grp        = grp;
    item.blk        = blk;
    item.len        = len;
    item.last       = last;
    item.off        = off;
    item.geom_bad   = geom_bad;
    item.bounds_bad = bounds_bad;
  end

endmodule

// ----- sv/elcc_queue.sv -----
// ----------------------------------------------------------------------------
// elcc_queue
// Short FIFO between the classifier and the list checker.
// ----------------------------------------------------------------------------
module elcc_queue
  import elcc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  nonempty,
  output item_t head
);

  item_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign nonempty = (cnt_r != '0);
  assign head     = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- sv/elcc_back.sv -----
// ----------------------------------------------------------------------------
// elcc_back
// List checker: count, order and overlap against the previous extent,
// sticky error, group accumulators and the result register.
// ----------------------------------------------------------------------------
module elcc_back
  import elcc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nonempty,
  input  item_t            q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output status_t          out_status,
  output logic             out_done,
  output logic [63:0]      out_mask,
  output logic             out_wide,
  output logic [CNT_W-1:0] out_count
);

  logic [31:0]      prev_group_r, prev_group_nxt;
  logic [63:0]      prev_block_r, prev_block_nxt;
  logic [31:0]      prev_length_r, prev_length_nxt;
  logic [64:0]      prev_end_r, prev_end_nxt;   // prev offset + prev length
  logic             have_prev_r, have_prev_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic [63:0]      mask_r, mask_nxt;
  logic             wide_r, wide_nxt;
  status_t          err_r, err_nxt;

  logic             valid_r;
  status_t          status_r, status_nxt;
  logic             done_r;
  logic [63:0]      omask_r, omask_nxt;
  logic             owide_r, owide_nxt;
  logic [CNT_W-1:0] ocount_r;

  status_t          chk;
  logic             before_prev;
  logic             hits_prev;
  logic             take;

  assign q_pop      = q_nonempty && (!valid_r || out_ready);
  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_done   = done_r;
  assign out_mask   = omask_r;
  assign out_wide   = owide_r;
  assign out_count  = ocount_r;

  assign before_prev = {q_head.grp, q_head.blk, q_head.len} <
                       {prev_group_r, prev_block_r, prev_length_r};
  assign hits_prev   = (q_head.grp == prev_group_r) &&
                       (prev_end_r > {1'b0, q_head.off});

  always_comb begin
    if (q_head.geom_bad) begin
      chk = ST_GEOM;
    end else if (seen_r >= CNT_W'(MAX_ENTRIES)) begin
      chk = ST_MANY;
    end else if (q_head.bounds_bad) begin
      chk = ST_BOUNDS;
    end else if (have_prev_r && before_prev) begin
      chk = ST_ORDER;
    end else if (have_prev_r && hits_prev) begin
      chk = ST_OVERLAP;
    end else begin
      chk = ST_OK;
    end

    take            = (err_r == ST_OK) && (chk == ST_OK);
    err_nxt         = (err_r != ST_OK) ? err_r : chk;
    seen_nxt        = (seen_r < CNT_W'(MAX_ENTRIES)) ? seen_r + 1'b1 : seen_r;
    prev_group_nxt  = take ? q_head.grp : prev_group_r;
    prev_block_nxt  = take ? q_head.blk : prev_block_r;
    prev_length_nxt = take ? q_head.len : prev_length_r;
    prev_end_nxt    = take ? ({1'b0, q_head.off} + {33'd0, q_head.len}) : prev_end_r;
    have_prev_nxt   = take ? 1'b1 : have_prev_r;
    wide_nxt        = wide_r;
    mask_nxt        = mask_r;
    if (take) begin
      if (q_head.grp >= 32'd64) begin
        wide_nxt = 1'b1;
      end else begin
        mask_nxt = mask_r | (64'd1 << q_head.grp[5:0]);
      end
    end

    status_nxt = err_nxt;
    omask_nxt  = ((err_nxt != ST_OK) || wide_nxt) ? 64'd0 : mask_nxt;
    owide_nxt  = (err_nxt == ST_OK) && wide_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_group_r  <= '0;
      prev_block_r  <= '0;
      prev_length_r <= '0;
      prev_end_r    <= '0;
      have_prev_r   <= 1'b0;
      seen_r        <= '0;
      mask_r        <= '0;
      wide_r        <= 1'b0;
      err_r         <= ST_OK;
      valid_r       <= 1'b0;
    end else begin
      if (q_pop) begin
        valid_r <= 1'b1;
        if (q_head.last) begin
          prev_group_r  <= '0;
          prev_block_r  <= '0;
          prev_length_r <= '0;
          prev_end_r    <= '0;
          have_prev_r   <= 1'b0;
          seen_r        <= '0;
          mask_r        <= '0;
          wide_r        <= 1'b0;
          err_r         <= ST_OK;
        end else begin
          prev_group_r  <= prev_group_nxt;
          prev_block_r  <= prev_block_nxt;
          prev_length_r <= prev_length_nxt;
          prev_end_r    <= prev_end_nxt;
          have_prev_r   <= have_prev_nxt;
          seen_r        <= seen_nxt;
          mask_r        <= mask_nxt;
          wide_r        <= wide_nxt;
          err_r         <= err_nxt;
        end
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      done_r   <= q_head.last;
      omask_r  <= omask_nxt;
      owide_r  <= owide_nxt;
      ocount_r <= seen_nxt;
    end
  end

endmodule

// ----- sv/extent_list_canonical_check_core.sv -----
// ----------------------------------------------------------------------------
// extent_list_canonical_check_core
// Checks a stream of block extents for a valid, canonical extent list.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one extent per item (group, block, length; tlast ends the list).
//   out_* : one result per extent: sticky status, group mask, count; tlast
//           echoes the end of list, tuser carries the fs-wide flag.
//   cfg_* : APB-style geometry registers at 0x0, 0x4, 0x8; write only while
//           the stream is idle. pready is tied high.
// Timing: one extent per cycle sustained while out_tready stays high. A result
//   is registered: the classified extent enters a four-entry queue when it
//   is accepted, and the list checker then loads the result register from
//   the queue head. The list checker compares each extent against the
//   previous one.
// Stall: a held result keeps the checker waiting; the queue absorbs up to
//   four more extents before in_tready drops.
// Reset: list state, queue and result valid clear; geometry reads zero,
//   which reports bad geometry until written. State also clears after each
//   result with tlast set.
// ----------------------------------------------------------------------------
module extent_list_canonical_check_core
  import elcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // [31:0] group_index, [95:32] fs_block, [127:96] extent_length
  input  logic [127:0]      in_tdata,
  input  logic              in_tlast,
  input  logic              in_tvalid,
  output logic              in_tready,
  // [2:0] status, [66:3] group_mask, [77:67] entry_count, [79:78] zero
  output logic [79:0]       out_tdata,
  output logic              out_tlast,
  // [0] fs_wide
  output logic              out_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t             cfg;
  item_t            f_item;
  item_t            q_head;
  logic             q_full;
  logic             q_nonempty;
  logic             q_pop;
  logic             push;
  status_t          b_status;
  logic [63:0]      b_mask;
  logic [CNT_W-1:0] b_count;

  assign cfg_pready = 1'b1;
  assign in_tready  = !q_full;
  assign push       = in_tvalid && !q_full;
  assign out_tdata  = {2'b00, b_count, b_mask, b_status};

  elcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  elcc_front u_front (
    .cfg  (cfg),
    .grp  (in_tdata[31:0]),
    .blk  (in_tdata[95:32]),
    .len  (in_tdata[127:96]),
    .last (in_tlast),
    .item (f_item)
  );

  elcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      (q_head)
  );

  elcc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (b_status),
    .out_done   (out_tlast),
    .out_mask   (b_mask),
    .out_wide   (out_tuser),
    .out_count  (b_count)
  );

endmodule

// ----- tb/elcc_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elcc_list_checker
// Watches the extent stream, the result stream and the register port of the
// extent list checker. It keeps its own copy of the geometry and of the list
// state, predicts the result of every accepted extent and compares each
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module elcc_list_checker
  import elcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [127:0]      in_tdata,
  input  logic              in_tlast,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [79:0]       out_tdata,
  input  logic              out_tlast,
  input  logic              out_tuser,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int                fail_count,
  output int                verdicts_due
);

  typedef enum logic [ADDR_W-3:0] {
    REG_GROUP_COUNT  = 0,
    REG_GROUP_BLOCKS = 1,
    REG_BLOCK_LOG    = 2
  } reg_index_t;

  typedef struct packed {
    status_t          status;
    logic             done;
    logic [63:0]      mask;
    logic             wide;
    logic [CNT_W-1:0] count;
  } verdict_t;

  verdict_t verdict_q[$];

  // geometry copy
  logic [31:0] geo_groups;
  logic [31:0] geo_blocks;
  logic [5:0]  geo_log;

  // per-list state
  logic [31:0]      last_grp;
  logic [63:0]      last_blk;
  logic [31:0]      last_len;
  logic             have_last;
  logic [CNT_W-1:0] seen;
  logic [63:0]      touched;
  logic             wide_seen;
  status_t          sticky;

  task automatic clear_list();
    last_grp  = '0;
    last_blk  = '0;
    last_len  = '0;
    have_last = 1'b0;
    seen      = '0;
    touched   = '0;
    wide_seen = 1'b0;
    sticky    = ST_OK;
  endtask

  // checks in priority order: geometry, count, bounds, order, overlap
  function automatic status_t judge_extent(input logic [31:0] grp, input logic [63:0] blk,
                                           input logic [31:0] len);
    logic [63:0] off_mask;
    logic [63:0] off;
    if (geo_groups == 0 || geo_blocks == 0 || geo_log == 0) return ST_GEOM;
    if (seen >= MAX_ENTRIES) return ST_MANY;
    off_mask = (64'd1 << geo_log) - 64'd1;
    off = blk & off_mask;
    if (len == 0 || grp >= geo_groups) return ST_BOUNDS;
    if ((blk >> geo_log) != {32'd0, grp}) return ST_BOUNDS;
    if (off >= {32'd0, geo_blocks} || {32'd0, len} > {32'd0, geo_blocks} - off)
      return ST_BOUNDS;
    if (have_last) begin
      if (grp < last_grp || (grp == last_grp &&
          (blk < last_blk || (blk == last_blk && len < last_len))))
        return ST_ORDER;
      if (grp == last_grp && (last_blk & off_mask) + {32'd0, last_len} > off)
        return ST_OVERLAP;
    end
    return ST_OK;
  endfunction

  always @(posedge clk) begin : watch
    verdict_t    want;
    status_t     st;
    logic [31:0] grp;
    logic [63:0] blk;
    logic [31:0] len;
    logic [31:0] rd_want;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      geo_groups = '0;
      geo_blocks = '0;
      geo_log    = '0;
      clear_list();
      verdict_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[ADDR_W-1:2])
            REG_GROUP_COUNT:  geo_groups = cfg_pwdata;
            REG_GROUP_BLOCKS: geo_blocks = cfg_pwdata;
            REG_BLOCK_LOG:    geo_log    = cfg_pwdata[5:0];
            default: ;
          endcase
        end else if (cfg_paddr[ADDR_W-1:2] <= REG_BLOCK_LOG) begin
          case (cfg_paddr[ADDR_W-1:2])
            REG_GROUP_COUNT:  rd_want = geo_groups;
            REG_GROUP_BLOCKS: rd_want = geo_blocks;
            default:          rd_want = {26'd0, geo_log};
          endcase
          if (cfg_prdata !== rd_want) begin
            $error("prdata: expected %0h, got %0h", rd_want, cfg_prdata);
            errs++;
          end
        end
      end

      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result accepted with no extent outstanding");
          errs++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[2:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_tdata[2:0]);
            errs++;
          end
          if (out_tlast !== want.done) begin
            $error("list_done: expected %0d, got %0d", want.done, out_tlast);
            errs++;
          end
          if (out_tdata[66:3] !== want.mask) begin
            $error("group_mask: expected %0h, got %0h", want.mask, out_tdata[66:3]);
            errs++;
          end
          if (out_tuser !== want.wide) begin
            $error("fs_wide: expected %0d, got %0d", want.wide, out_tuser);
            errs++;
          end
          if (out_tdata[77:67] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, out_tdata[77:67]);
            errs++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        grp = in_tdata[31:0];
        blk = in_tdata[95:32];
        len = in_tdata[127:96];
        // once an error is latched, the extent only advances the count
        if (sticky == ST_OK) begin
          st = judge_extent(grp, blk, len);
          if (st != ST_OK) begin
            sticky = st;
          end else begin
            if (grp >= 32'd64) wide_seen = 1'b1;
            else touched = touched | (64'd1 << grp[5:0]);
            last_grp  = grp;
            last_blk  = blk;
            last_len  = len;
            have_last = 1'b1;
          end
        end
        if (seen < MAX_ENTRIES) seen = seen + 1'b1;
        want.status = sticky;
        want.done   = in_tlast;
        want.mask   = (sticky != ST_OK || wide_seen) ? 64'd0 : touched;
        want.wide   = (sticky == ST_OK) && wide_seen;
        want.count  = seen;
        verdict_q.push_back(want);
        if (in_tlast) clear_list();
      end
      fail_count <= fail_count + errs;
    end
    verdicts_due <= verdict_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the extent list checker: directed extents for each error
// kind, then random lists (mostly well-formed, some broken, some noise)
// under several geometry settings, and one list past the entry limit.
// Both stream sides idle at random; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import elcc_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_GROUP_COUNT  = 'h0;
  localparam logic [ADDR_W-1:0] ADDR_GROUP_BLOCKS = 'h4;
  localparam logic [ADDR_W-1:0] ADDR_BLOCK_LOG    = 'h8;
  localparam logic [ADDR_W-1:0] ADDR_SPARE        = 'hC;
  localparam int STALL_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 12;
  localparam int NUM_PHASES   = 10;

  typedef struct packed {
    logic [31:0] g;
    logic [63:0] b;
    logic [31:0] len;
  } extent_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic [127:0]      in_tdata = '0;
  logic              in_tlast = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [79:0]       out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              out_tvalid;
  logic              out_tready = 1'b1;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  int                fail_count;
  int                verdicts_due;
  int                quiet_cycles = 0;

  // geometry as last written, and the well-formed list generator
  logic [31:0] geo_count;
  logic [31:0] geo_blocks;
  logic [5:0]  geo_log = '0;
  logic        geo_ok;
  logic [63:0] grp_room;
  logic [63:0] grp_top;
  logic [63:0] cur_grp;
  logic [63:0] cur_off;
  logic        dense;
  extent_t     run_q[$];

  extent_list_canonical_check_core u_top (.*);
  elcc_list_checker u_check (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable))
      quiet_cycles <= 0;
    else if (quiet_cycles == STALL_LIMIT) begin
      $display("extent_list_canonical_check_core regression: fail");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : result_stalls
    int hold;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      hold = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      repeat (hold) @(posedge clk);
      if ($urandom_range(0, 99) < 70) begin
        out_tready <= 1'b0;
        hold = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        repeat (hold) @(posedge clk);
      end
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int list_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 40);
    return $urandom_range(41, 120);
  endfunction

  task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [31:0] cnt, input logic [31:0] blks,
                              input logic [31:0] log_word);
    logic [63:0] pow;
    logic [63:0] cap;
    apb_access(1'b1, ADDR_GROUP_COUNT, cnt);
    apb_access(1'b1, ADDR_GROUP_BLOCKS, blks);
    apb_access(1'b1, ADDR_BLOCK_LOG, log_word);
    // unmapped register: must leave the geometry alone
    apb_access(1'b1, ADDR_SPARE, $urandom);
    apb_access(1'b0, ADDR_GROUP_COUNT, '0);
    apb_access(1'b0, ADDR_GROUP_BLOCKS, '0);
    apb_access(1'b0, ADDR_BLOCK_LOG, '0);
    geo_count  = cnt;
    geo_blocks = blks;
    geo_log    = log_word[5:0];
    geo_ok     = cnt != 0 && blks != 0 && geo_log != 0;
    pow        = 64'd1 << geo_log;
    grp_room   = ({32'd0, blks} < pow) ? {32'd0, blks} : pow;
    // the group number must survive the shift into fs_block
    cap        = (geo_log <= 32) ? 64'hFFFF_FFFF : (64'd1 << (64 - geo_log)) - 64'd1;
    grp_top    = ({32'd0, cnt} - 64'd1 < cap) ? {32'd0, cnt} - 64'd1 : cap;
  endtask

  task automatic send_item(input extent_t e, input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {e.len, e.b, e.g};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (verdicts_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic extent_t ext(input logic [31:0] g, input logic [63:0] off,
                                  input logic [31:0] len);
    extent_t e;
    e.g   = g;
    e.b   = ({32'd0, g} << geo_log) | off;
    e.len = len;
    return e;
  endfunction

  function automatic extent_t noise_extent();
    extent_t e;
    e.g   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 130);
    e.b   = $urandom_range(0, 1) ? {$urandom, $urandom}
                                 : (({32'd0, e.g} << geo_log) | $urandom_range(0, 2000));
    e.len = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);
    return e;
  endfunction

  // spoil one extent of a well-formed list
  function automatic extent_t break_extent(input int k);
    extent_t     e;
    extent_t     p;
    logic [63:0] off;
    e = run_q[k];
    p = (k > 0) ? run_q[k-1] : run_q[k];
    case ($urandom_range(0, 6))
      0: e = p;
      1: e.len = '0;
      2: begin
        e = p;
        e.len = p.len - 1;
      end
      3: begin
        e = p;
        if (p.len > 1) e.b = p.b + 1;
        e.len = 1;
      end
      4: e.b = e.b ^ (64'd1 << $urandom_range(geo_log, 63));
      5: e.g = geo_count + $urandom_range(0, 3);
      default: begin
        off = e.b & ((64'd1 << geo_log) - 64'd1);
        e.len = 32'(grp_room - off + 64'd1);
      end
    endcase
    return e;
  endfunction

  task automatic next_extent(output logic ok, output extent_t e);
    logic [63:0] room;
    logic [31:0] span;
    ok = 1'b0;
    e  = '0;
    if (cur_off >= grp_room || (!dense && $urandom_range(0, 9) == 0)) begin
      case ($urandom_range(0, 9))
        0, 1: cur_grp = cur_grp + $urandom_range(1, 100);
        2: cur_grp = (grp_top > cur_grp) ? cur_grp + $urandom_range(1, grp_top - cur_grp)
                                         : cur_grp + 1;
        default: cur_grp = cur_grp + $urandom_range(1, 3);
      endcase
      cur_off = (dense || $urandom_range(0, 2) != 0) ? 64'd0 : $urandom_range(0, grp_room - 1);
    end
    if (cur_grp > grp_top) return;
    room = grp_room - cur_off;
    if (dense)
      span = (room >= 2 && $urandom_range(0, 1) == 1) ? 2 : 1;
    else if ($urandom_range(0, 3) != 0)
      span = $urandom_range(1, (room < 4) ? room : 4);
    else
      span = $urandom_range(1, room);
    e.g   = cur_grp[31:0];
    e.b   = (cur_grp << geo_log) | cur_off;
    e.len = span;
    ok    = 1'b1;
    cur_off = cur_off + span;
    if (!dense && $urandom_range(0, 3) == 0) cur_off = cur_off + $urandom_range(0, 20);
  endtask

  task automatic play_list(input int n, input logic packed_run, output int sent);
    extent_t e;
    logic    ok;
    int      k;
    run_q.delete();
    dense = packed_run;
    if (!packed_run && (!geo_ok || $urandom_range(0, 6) == 0)) begin
      repeat (n) run_q.push_back(noise_extent());
    end else begin
      if (packed_run) begin
        cur_grp = 0;
        cur_off = 0;
      end else begin
        cur_grp = $urandom_range(0, 1) ? $urandom_range(0, (grp_top < 3) ? grp_top : 3)
                                       : $urandom_range(0, grp_top);
        cur_off = $urandom_range(0, 1) ? 64'd0 : $urandom_range(0, grp_room - 1);
      end
      for (int i = 0; i < n; i++) begin
        next_extent(ok, e);
        if (!ok) break;
        run_q.push_back(e);
      end
      if (run_q.size() == 0) run_q.push_back(noise_extent());
      if (!packed_run && $urandom_range(0, 99) < 35) begin
        k = $urandom_range(0, run_q.size() - 1);
        run_q[k] = break_extent(k);
      end
    end
    foreach (run_q[i]) send_item(run_q[i], i == run_q.size() - 1);
    sent  = run_q.size();
    dense = 1'b0;
  endtask

  initial begin : stimulus
    int sent;
    int phase_sent;
    dense = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // geometry still at reset: everything is bad geometry
    send_item('1, 1'b0);
    send_item('0, 1'b0);
    send_item(ext(1, 2, 3), 1'b1);
    quiesce();

    set_geometry(100, 1000, 10);
    // clean list: group edges, exact fit, filesystem-wide group
    send_item(ext(0, 0, 1), 1'b0);
    send_item(ext(0, 1, 5), 1'b0);
    send_item(ext(0, 6, 994), 1'b0);
    send_item(ext(3, 0, 1), 1'b0);
    send_item(ext(63, 999, 1), 1'b0);
    send_item(ext(64, 0, 1), 1'b0);
    send_item(ext(99, 0, 1000), 1'b1);
    // duplicate, then the error sticks
    send_item(ext(5, 10, 4), 1'b0);
    send_item(ext(5, 10, 4), 1'b0);
    send_item(ext(6, 0, 1), 1'b1);
    // overlap inside a group
    send_item(ext(5, 10, 4), 1'b0);
    send_item(ext(5, 12, 1), 1'b1);
    // group goes backwards
    send_item(ext(7, 0, 1), 1'b0);
    send_item(ext(6, 0, 1), 1'b1);
    // bounds: empty, group too high, group bits wrong, offset past group, too long
    send_item(ext(2, 0, 0), 1'b1);
    send_item(ext(100, 0, 1), 1'b1);
    send_item('{g: 32'd2, b: (64'd3 << 10) | 64'd5, len: 32'd1}, 1'b1);
    send_item(ext(2, 1000, 1), 1'b1);
    send_item(ext(2, 990, 11), 1'b1);
    // same start, shorter length
    send_item(ext(4, 20, 3), 1'b0);
    send_item(ext(4, 20, 2), 1'b1);
    quiesce();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: ;
        1: set_geometry($urandom_range(1, 300), $urandom_range(1, 70000), $urandom_range(4, 24));
        2: set_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32);
        3: set_geometry(1, 1, 1);
        4: set_geometry(2, 3, 63);
        5: set_geometry(32'hFFFF_FFFF, 1, 6);
        6: set_geometry($urandom_range(60, 140), $urandom_range(1, 600), $urandom_range(9, 12));
        7: set_geometry(70, 500, 32'h40);
        8: set_geometry(0, 500, 9);
        default: set_geometry(70, 0, 9);
      endcase
      phase_sent = 0;
      while (phase_sent < (geo_ok ? PHASE_ITEMS : 4)) begin
        play_list(list_len(), 1'b0, sent);
        phase_sent += sent;
      end
      quiesce();
    end

    // one clean list that runs past the entry limit, then a fresh list
    set_geometry(8, 4000, 12);
    play_list(MAX_ENTRIES + $urandom_range(2, 12), 1'b1, sent);
    play_list(3, 1'b0, sent);
    quiesce();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && verdicts_due == 0)
      $display("extent_list_canonical_check_core regression: pass");
    else
      $display("extent_list_canonical_check_core regression: fail");
    $finish;
  end

endmodule
